FILE: rtl/pdpwm_pkg.sv
`default_nettype none
package pdpwm_pkg;

  localparam int FREQ_W    = 20;
  localparam int DUTY_W    = 7;
  localparam int PRE_W     = 11;
  localparam int PER_W     = 17;
  localparam int DIV_W     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 4;

  localparam int FREQ_MIN     = 1;
  localparam int FREQ_MAX     = 999999;
  localparam int PERCENT      = 100;
  localparam int PRESCALE_MAX = 2047;
  localparam int PERIOD_MAX   = 131071;

  // floor(x / 100) == (x * PUL_RECIP) >> PUL_SHIFT for every x below 2^25
  localparam int PUL_RECIP_W = 25;
  localparam int PUL_SHIFT   = 31;
  localparam int PUL_RECIP   = 21474837;

  localparam int RST_FREQ = 200;
  localparam int RST_DUTY = 70;
  localparam int RST_INV  = 0;

  typedef enum logic [1:0] {
    REG_FREQ = 2'd0,
    REG_DUTY = 2'd1,
    REG_INV  = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    SEL_PRE = 2'd0,
    SEL_PER = 2'd1
  } div_sel_e;

  typedef struct packed {
    logic     busy;
    logic     div_start;
    div_sel_e div_sel;
    logic     load_pre;
    logic     load_per;
    logic     load_pulse;
  } cmd_t;

  typedef struct packed {
    logic recalc_req;
    logic div_done;
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/percent_duty_pwm_generator_unit.sv
// Percent-duty PWM generator.
// Configuration: APB-style port, freq_hz at 0x0, duty_percent at 0x4,
// invert at 0x8; out-of-range frequency or duty writes are dropped.
// Input channel (in_valid_i / in_stall_o): one item per system tick carrying
// run_i and stop_level_i. Output channel (out_valid_o / out_stall_i): one
// item per input item with pin_level_o and period_start_o.
// Throughput: one item per cycle while the input is not stalled. The result
// sits in the output register in the cycle after the item is taken.
// A frequency or duty write recomputes prescale and period with one shared
// bit-serial divider (two 32-step divisions) and the pulse with a reciprocal
// multiply; the input channel stalls from the write until the recompute ends.
// Counters keep their values.
// Reset: registers return to 200 Hz, 70 percent, not inverted; derived values
// load at once, counters clear, output register empties.
// Receiver stall: the output item holds, and the input stalls until it drains.
`default_nettype none
module percent_duty_pwm_generator_unit #(
  parameter int CLOCK_HZ      = 100000000,
  parameter int PRESCALE_BASE = 1536
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pdpwm_pkg::APB_AW-1:0]  paddr,
  input  wire logic [pdpwm_pkg::APB_DW-1:0]  pwdata,
  output logic [pdpwm_pkg::APB_DW-1:0]       prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          run_i,
  input  wire logic                          stop_level_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               pin_level_o,
  output logic                               period_start_o
);

  pdpwm_pkg::cmd_t    cmd;
  pdpwm_pkg::status_t sts;

  assign pready = 1'b1;

  pdpwm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  pdpwm_dp #(
    .CLOCK_HZ      (CLOCK_HZ),
    .PRESCALE_BASE (PRESCALE_BASE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .run_i          (run_i),
    .stop_level_i   (stop_level_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pin_level_o    (pin_level_o),
    .period_start_o (period_start_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule
`default_nettype wire

FILE: rtl/pdpwm_div.sv
`default_nettype none
module pdpwm_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [pdpwm_pkg::DIV_W-1:0]  dividend_i,
  input  wire logic [pdpwm_pkg::DIV_W-1:0]  divisor_i,
  output logic                              done_o,
  output logic [pdpwm_pkg::DIV_W-1:0]       quotient_o
);

  localparam int W  = pdpwm_pkg::DIV_W;
  localparam int CW = pdpwm_pkg::DIV_CNT_W;

  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  dvs_q, dvs_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          run_q, run_d;
  logic          done_q, done_d;
  logic [W:0]    rem_sh;
  logic [W:0]    diff;
  logic          take;

  assign rem_sh = {rem_q, quo_q[W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign take   = ~diff[W];

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      quo_d = {quo_q[W-2:0], take};
      rem_d = take ? diff[W-1:0] : rem_sh[W-1:0];
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

FILE: rtl/pdpwm_dp.sv
`default_nettype none
module pdpwm_dp #(
  parameter int CLOCK_HZ      = 100000000,
  parameter int PRESCALE_BASE = 1536
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pdpwm_pkg::APB_AW-1:0]  paddr,
  input  wire logic [pdpwm_pkg::APB_DW-1:0]  pwdata,
  output logic [pdpwm_pkg::APB_DW-1:0]       prdata,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          run_i,
  input  wire logic                          stop_level_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               pin_level_o,
  output logic                               period_start_o,
  input  wire pdpwm_pkg::cmd_t               cmd_i,
  output pdpwm_pkg::status_t                 sts_o
);

  localparam int FW = pdpwm_pkg::FREQ_W;
  localparam int DW = pdpwm_pkg::DUTY_W;
  localparam int PW = pdpwm_pkg::PRE_W;
  localparam int TW = pdpwm_pkg::PER_W;
  localparam int VW = pdpwm_pkg::DIV_W;
  localparam int AW = pdpwm_pkg::APB_DW;
  localparam int NW = TW + DW;
  localparam int RW = pdpwm_pkg::PUL_RECIP_W;

  localparam int RST_PRE_RAW = PRESCALE_BASE / pdpwm_pkg::RST_FREQ;
  localparam int RST_PRE     = (RST_PRE_RAW > pdpwm_pkg::PRESCALE_MAX) ?
                               pdpwm_pkg::PRESCALE_MAX : RST_PRE_RAW;
  localparam int RST_PER_RAW = CLOCK_HZ / ((RST_PRE + 1) * pdpwm_pkg::RST_FREQ);
  localparam int RST_PER     = (RST_PER_RAW > pdpwm_pkg::PERIOD_MAX) ?
                               pdpwm_pkg::PERIOD_MAX : RST_PER_RAW;
  localparam int RST_PULSE   = RST_PER * pdpwm_pkg::RST_DUTY / pdpwm_pkg::PERCENT;

  logic [FW-1:0] freq_q;
  logic [DW-1:0] duty_q;
  logic          inv_q;
  logic [PW-1:0] pre_q;
  logic [TW-1:0] per_q;
  logic [TW-1:0] pulse_q;
  logic [PW-1:0] pre_cnt_q, pre_cnt_d;
  logic [TW-1:0] per_cnt_q, per_cnt_d;
  logic          out_valid_q, out_valid_d;
  logic          pin_q, pin_d;
  logic          start_q, start_d;
  logic [NW-1:0] pul_num_q, pul_num_d;

  logic                cfg_we;
  pdpwm_pkg::reg_idx_e idx;
  logic                freq_ok;
  logic                duty_ok;
  logic                wr_freq;
  logic                wr_duty;
  logic                wr_inv;
  logic                recalc_req;
  logic                accept;
  logic                wrap;
  logic                active;

  logic [VW-1:0]    div_a;
  logic [VW-1:0]    div_b;
  logic [VW-1:0]    quo;
  logic             div_done;
  logic [PW:0]      pre_inc;
  logic [VW-1:0]    per_div;
  logic [NW+RW-1:0] pul_prod;

  assign cfg_we  = psel & penable & pwrite;
  assign idx     = pdpwm_pkg::reg_idx_e'(paddr[3:2]);
  assign freq_ok = (pwdata >= AW'(pdpwm_pkg::FREQ_MIN)) &&
                   (pwdata <= AW'(pdpwm_pkg::FREQ_MAX));
  assign duty_ok = pwdata <= AW'(pdpwm_pkg::PERCENT);

  always_comb begin
    wr_freq = 1'b0;
    wr_duty = 1'b0;
    wr_inv  = 1'b0;
    prdata  = '0;
    unique case (idx)
      pdpwm_pkg::REG_FREQ: begin
        wr_freq = cfg_we & freq_ok;
        prdata  = AW'(freq_q);
      end
      pdpwm_pkg::REG_DUTY: begin
        wr_duty = cfg_we & duty_ok;
        prdata  = AW'(duty_q);
      end
      pdpwm_pkg::REG_INV: begin
        wr_inv = cfg_we;
        prdata = AW'(inv_q);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  assign recalc_req = wr_freq | wr_duty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= FW'(pdpwm_pkg::RST_FREQ);
      duty_q <= DW'(pdpwm_pkg::RST_DUTY);
      inv_q  <= 1'(pdpwm_pkg::RST_INV);
    end else begin
      if (wr_freq) begin
        freq_q <= pwdata[FW-1:0];
      end
      if (wr_duty) begin
        duty_q <= pwdata[DW-1:0];
      end
      if (wr_inv) begin
        inv_q <= pwdata[0];
      end
    end
  end

  assign pre_inc   = {1'b0, pre_q} + (PW + 1)'(1);
  assign per_div   = {{(VW - PW - 1){1'b0}}, pre_inc} * {{(VW - FW){1'b0}}, freq_q};
  assign pul_num_d = {{DW{1'b0}}, per_q} * {{TW{1'b0}}, duty_q};
  assign pul_prod  = {{RW{1'b0}}, pul_num_q} * (NW + RW)'(pdpwm_pkg::PUL_RECIP);

  always_comb begin
    unique case (cmd_i.div_sel)
      pdpwm_pkg::SEL_PRE: begin
        div_a = VW'(PRESCALE_BASE);
        div_b = VW'(freq_q);
      end
      pdpwm_pkg::SEL_PER: begin
        div_a = VW'(CLOCK_HZ);
        div_b = per_div;
      end
      default: begin
        div_a = VW'(PRESCALE_BASE);
        div_b = VW'(freq_q);
      end
    endcase
  end

  pdpwm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q   <= PW'(RST_PRE);
      per_q   <= TW'(RST_PER);
      pulse_q <= TW'(RST_PULSE);
    end else begin
      if (cmd_i.load_pre) begin
        pre_q <= (quo > VW'(pdpwm_pkg::PRESCALE_MAX)) ?
                 PW'(pdpwm_pkg::PRESCALE_MAX) : quo[PW-1:0];
      end
      if (cmd_i.load_per) begin
        per_q <= (quo > VW'(pdpwm_pkg::PERIOD_MAX)) ?
                 TW'(pdpwm_pkg::PERIOD_MAX) : quo[TW-1:0];
      end
      if (cmd_i.load_pulse) begin
        pulse_q <= pul_prod[pdpwm_pkg::PUL_SHIFT +: TW];
      end
    end
  end

  assign sts_o.recalc_req = recalc_req;
  assign sts_o.div_done   = div_done;

  assign in_stall_o = cmd_i.busy | recalc_req | (out_valid_q & out_stall_i);
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    pre_cnt_d = pre_cnt_q;
    per_cnt_d = per_cnt_q;
    wrap      = 1'b0;
    if (pre_cnt_q >= pre_q) begin
      pre_cnt_d = '0;
      if (per_cnt_q >= per_q) begin
        per_cnt_d = '0;
        wrap      = 1'b1;
      end else begin
        per_cnt_d = per_cnt_q + TW'(1);
      end
    end else begin
      pre_cnt_d = pre_cnt_q + PW'(1);
    end
    if (duty_q >= DW'(pdpwm_pkg::PERCENT)) begin
      active = 1'b1;
    end else if (duty_q == '0) begin
      active = 1'b0;
    end else begin
      active = per_cnt_d < pulse_q;
    end
    pin_d   = (run_i ? active : stop_level_i) ^ inv_q;
    start_d = run_i & wrap;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_cnt_q   <= '0;
      per_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept && run_i) begin
        pre_cnt_q <= pre_cnt_d;
        per_cnt_q <= per_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pul_num_q <= pul_num_d;
    if (accept) begin
      pin_q   <= pin_d;
      start_q <= start_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pin_level_o    = pin_q;
  assign period_start_o = start_q;

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted item did not reach output register");

  a_pulse_in_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.busy |-> pulse_q <= per_q)
    else $error("pulse exceeds period after recompute");

  a_counters_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept && run_i) |=> $stable(pre_cnt_q) && $stable(per_cnt_q))
    else $error("counters moved without a running item");

  a_stop_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !run_i |=> pin_q == ($past(stop_level_i) ^ $past(inv_q)))
    else $error("stopped pin level wrong");

endmodule
`default_nettype wire

FILE: rtl/pdpwm_ctrl.sv
`default_nettype none
module pdpwm_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire pdpwm_pkg::status_t  sts_i,
  output pdpwm_pkg::cmd_t          cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_PRE_GO = 7'b0000010,
    ST_PRE_WT = 7'b0000100,
    ST_PER_GO = 7'b0001000,
    ST_PER_WT = 7'b0010000,
    ST_PUL_GO = 7'b0100000,
    ST_PUL_WT = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d          = state_q;
    cmd_o.busy       = state_q != ST_IDLE;
    cmd_o.div_start  = 1'b0;
    cmd_o.div_sel    = pdpwm_pkg::SEL_PRE;
    cmd_o.load_pre   = 1'b0;
    cmd_o.load_per   = 1'b0;
    cmd_o.load_pulse = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        state_d = ST_IDLE;
      end
      ST_PRE_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = pdpwm_pkg::SEL_PRE;
        state_d         = ST_PRE_WT;
      end
      ST_PRE_WT: begin
        if (sts_i.div_done) begin
          cmd_o.load_pre = 1'b1;
          state_d        = ST_PER_GO;
        end
      end
      ST_PER_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = pdpwm_pkg::SEL_PER;
        state_d         = ST_PER_WT;
      end
      ST_PER_WT: begin
        if (sts_i.div_done) begin
          cmd_o.load_per = 1'b1;
          state_d        = ST_PUL_GO;
        end
      end
      ST_PUL_GO: begin
        state_d = ST_PUL_WT;
      end
      ST_PUL_WT: begin
        cmd_o.load_pulse = 1'b1;
        state_d          = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (sts_i.recalc_req) begin
      state_d = ST_PRE_GO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire
